@@ design/mes_pkg.sv @@
`timescale 1ns / 1ps

package mes_pkg;

  localparam int PROSIGN_DEPTH = 4;
  localparam int MAX_ELEMENTS = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam int OP_W = 2;
  localparam int LEN_W = 4;
  localparam int PBITS_W = 8;
  localparam int KIND_W = 2;
  localparam int DUR_W = 24;
  localparam int CFG_IDX_W = 3;

  localparam int ESC_W = $clog2(PROSIGN_DEPTH);
  localparam int CNT_W = $clog2(PROSIGN_DEPTH + 1);
  localparam int EL_W = $clog2(MAX_ELEMENTS);
  localparam int QP_W = $clog2(QUEUE_DEPTH);
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [OP_W-1:0] OP_CHAR = 2'd0;
  localparam logic [OP_W-1:0] OP_SPACE = 2'd1;
  localparam logic [OP_W-1:0] OP_ESCAPE = 2'd2;

  localparam logic [KIND_W-1:0] KIND_DOWN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PAUSE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_GAP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LETTER_GAP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_GAP = 3'd4;

  localparam logic [DUR_W-1:0] DIT_RESET = 24'd2880;
  localparam logic [DUR_W-1:0] DAH_RESET = 24'd8640;
  localparam logic [DUR_W-1:0] ELEMENT_GAP_RESET = 24'd2880;
  localparam logic [DUR_W-1:0] LETTER_GAP_RESET = 24'd8640;
  localparam logic [DUR_W-1:0] WORD_GAP_RESET = 24'd20160;

  typedef struct packed {
    logic                    is_space;
    logic [LEN_W-1:0]        len;
    logic [MAX_ELEMENTS-1:0] bits;
  } mes_held_t;

  typedef struct packed {
    logic                    is_space;
    logic [LEN_W-1:0]        len;
    logic [MAX_ELEMENTS-1:0] bits;
    logic                    cont;
    logic                    ends;
  } mes_job_t;

  typedef struct packed {
    logic [DUR_W-1:0] dit;
    logic [DUR_W-1:0] dah;
    logic [DUR_W-1:0] element_gap;
    logic [DUR_W-1:0] letter_gap;
    logic [DUR_W-1:0] word_gap;
  } mes_cfg_t;

endpackage

@@ design/mes_queue.sv @@
`timescale 1ns / 1ps

module mes_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mes_pkg::mes_job_t push_data,
  output logic             full,
  input  logic             pop,
  output mes_pkg::mes_job_t pop_data,
  output logic             empty
);
  import mes_pkg::*;

  mes_job_t         entries [QUEUE_DEPTH];
  logic [QP_W-1:0]  wr_ptr;
  logic [QP_W-1:0]  rd_ptr;
  logic [QC_W-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full = (count == QC_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QP_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QP_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QC_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

@@ design/mes_front.sv @@
`timescale 1ns / 1ps

module mes_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mes_pkg::OP_W-1:0]      op,
  input  logic [mes_pkg::LEN_W-1:0]     pattern_length,
  input  logic [mes_pkg::PBITS_W-1:0]   pattern_bits,
  output logic                          q_push,
  output mes_pkg::mes_job_t             q_data,
  input  logic                          q_full
);
  import mes_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_FLUSH = 1'b1;

  logic             state;
  logic [ESC_W-1:0] escape_count;
  logic [ESC_W-1:0] held_count;
  logic [ESC_W-1:0] idx;
  logic [CNT_W-1:0] flush_n;
  mes_held_t        held_items [PROSIGN_DEPTH];
  logic [PROSIGN_DEPTH-1:0] emit_mask;

  logic             accept;
  logic             is_text;
  logic             direct;
  logic             hold;
  logic             flush_start;
  logic             flush_step;
  logic             last_idx;
  logic             later_emits;
  logic [LEN_W-1:0] len_sat;
  mes_held_t        new_item;
  logic             new_emits;
  mes_held_t        cur;

  assign in_ready = (state == ST_IDLE) && !q_full;
  assign accept = in_valid && in_ready;
  assign is_text = (op == OP_CHAR) || (op == OP_SPACE);
  assign direct = accept && is_text && (escape_count == '0);
  assign hold = accept && is_text && (escape_count != '0);
  assign flush_start = hold && (held_count >= escape_count);

  always_comb begin
    len_sat = (pattern_length > LEN_W'(MAX_ELEMENTS)) ? LEN_W'(MAX_ELEMENTS) : pattern_length;
    new_item.is_space = (op == OP_SPACE);
    new_item.len = new_item.is_space ? '0 : len_sat;
    new_item.bits = new_item.is_space ? '0 : pattern_bits[MAX_ELEMENTS-1:0];
    new_emits = new_item.is_space || (new_item.len != '0);
  end

  assign cur = held_items[idx];
  assign last_idx = ((CNT_W'(idx) + CNT_W'(1)) == flush_n);
  assign flush_step = (state == ST_FLUSH) && !q_full;

  always_comb begin
    later_emits = 1'b0;
    for (int j = 0; j < PROSIGN_DEPTH; j++) begin
      if (emit_mask[j] && (ESC_W'(j) > idx) && (CNT_W'(j) < flush_n)) begin
        later_emits = 1'b1;
      end
    end
  end

  always_comb begin
    if (state == ST_FLUSH) begin
      q_push = flush_step && emit_mask[idx];
      q_data.is_space = cur.is_space;
      q_data.len = cur.len;
      q_data.bits = cur.bits;
      q_data.cont = !last_idx;
      q_data.ends = !later_emits;
    end else begin
      q_push = direct && new_emits;
      q_data.is_space = new_item.is_space;
      q_data.len = new_item.len;
      q_data.bits = new_item.bits;
      q_data.cont = 1'b0;
      q_data.ends = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      escape_count <= '0;
      held_count <= '0;
      idx <= '0;
      flush_n <= '0;
    end else begin
      if (accept && (op == OP_ESCAPE) &&
          ((CNT_W'(escape_count) + CNT_W'(1)) < CNT_W'(PROSIGN_DEPTH))) begin
        escape_count <= escape_count + ESC_W'(1);
      end
      if (hold) begin
        if (flush_start) begin
          escape_count <= '0;
          held_count <= '0;
          state <= ST_FLUSH;
          idx <= '0;
          flush_n <= CNT_W'(held_count) + CNT_W'(1);
        end else begin
          held_count <= held_count + ESC_W'(1);
        end
      end
      if (flush_step) begin
        if (last_idx) begin
          state <= ST_IDLE;
        end else begin
          idx <= idx + ESC_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hold) begin
      held_items[held_count] <= new_item;
      emit_mask[held_count] <= new_emits;
    end
  end

`ifndef SYNTH
  a_push_room: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("item pushed into a full queue");
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= escape_count)
    else $error("held item count passed the escape count");
  a_flush_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) |-> (escape_count == '0) && (held_count == '0))
    else $error("prosign state not cleared during flush");
`endif

endmodule

@@ design/mes_back.sv @@
`timescale 1ns / 1ps

module mes_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  output logic                          q_pop,
  input  mes_pkg::mes_job_t             q_data,
  input  mes_pkg::mes_cfg_t             cfg,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mes_pkg::KIND_W-1:0]    event_kind,
  output logic [mes_pkg::DUR_W-1:0]     duration,
  output logic                          last
);
  import mes_pkg::*;

  logic             busy;
  mes_job_t         job;
  logic [EL_W-1:0]  elem;
  logic             phase;

  logic             fire;
  logic             elem_last;
  logic             done;
  logic [KIND_W-1:0] kind_next;
  logic [DUR_W-1:0] duration_next;
  logic             last_next;
  logic [DUR_W-1:0] pause_dur;

  assign q_pop = !busy && !q_empty;
  assign fire = busy && (!out_valid || out_ready);
  assign elem_last = ((LEN_W'(elem) + LEN_W'(1)) == job.len);
  assign pause_dur = (cfg.word_gap > cfg.letter_gap) ? (cfg.word_gap - cfg.letter_gap) : '0;

  always_comb begin
    if (job.is_space) begin
      kind_next = KIND_PAUSE;
      duration_next = pause_dur;
      last_next = job.ends;
      done = 1'b1;
    end else if (!phase) begin
      kind_next = KIND_DOWN;
      duration_next = job.bits[elem] ? cfg.dah : cfg.dit;
      last_next = 1'b0;
      done = 1'b0;
    end else begin
      kind_next = KIND_UP;
      duration_next = (!elem_last || job.cont) ? cfg.element_gap : cfg.letter_gap;
      last_next = job.ends && elem_last;
      done = elem_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
        job <= q_data;
        elem <= '0;
        phase <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
        event_kind <= kind_next;
        duration <= duration_next;
        last <= last_next;
        if (done) begin
          busy <= 1'b0;
        end else if (phase) begin
          phase <= 1'b0;
          elem <= elem + EL_W'(1);
        end else begin
          phase <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_job_emits: assert property (@(posedge clk) disable iff (rst)
    busy && !job.is_space |-> job.len != '0)
    else $error("character without elements reached the back end");
  a_elem_range: assert property (@(posedge clk) disable iff (rst)
    busy && !job.is_space |-> LEN_W'(elem) < job.len)
    else $error("element index ran past the pattern length");
`endif

endmodule

@@ design/morse_element_sequencer.sv @@
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// input     in_valid/in_ready    op, pattern_length, pattern_bits
// output    out_valid/out_ready  event_kind, duration, last
// config    cfg_write            cfg_index, cfg_data
//
// A character of n elements gives 2n events, one per cycle unless out_ready stalls the output,
// after the job is loaded into the element sequencer; a word space gives one event.
// A completed prosign is replayed from the hold store at one held item per cycle while the
// job queue is not full, and no input item is taken during that replay or while the queue is full.
// Reset is synchronous and clears the prosign state, the queue and the output.
// The output register holds its event while out_ready is low.

module morse_element_sequencer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mes_pkg::OP_W-1:0]      op,
  input  logic [mes_pkg::LEN_W-1:0]     pattern_length,
  input  logic [mes_pkg::PBITS_W-1:0]   pattern_bits,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mes_pkg::KIND_W-1:0]    event_kind,
  output logic [mes_pkg::DUR_W-1:0]     duration,
  output logic                          last,
  input  logic                          cfg_write,
  input  logic [mes_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mes_pkg::DUR_W-1:0]     cfg_data
);
  import mes_pkg::*;

  mes_cfg_t cfg;
  mes_job_t push_data;
  mes_job_t pop_data;
  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dit <= DIT_RESET;
      cfg.dah <= DAH_RESET;
      cfg.element_gap <= ELEMENT_GAP_RESET;
      cfg.letter_gap <= LETTER_GAP_RESET;
      cfg.word_gap <= WORD_GAP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DIT: cfg.dit <= cfg_data;
        CFG_DAH: cfg.dah <= cfg_data;
        CFG_ELEMENT_GAP: cfg.element_gap <= cfg_data;
        CFG_LETTER_GAP: cfg.letter_gap <= cfg_data;
        CFG_WORD_GAP: cfg.word_gap <= cfg_data;
        default: ;
      endcase
    end
  end

  mes_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .pattern_length (pattern_length),
    .pattern_bits   (pattern_bits),
    .q_push         (q_push),
    .q_data         (push_data),
    .q_full         (q_full)
  );

  mes_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  mes_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_data     (pop_data),
    .cfg        (cfg),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_kind (event_kind),
    .duration   (duration),
    .last       (last)
  );

endmodule

@@ sim/tb_morse_element_sequencer.sv @@
`timescale 1ns / 1ps

module tb_morse_element_sequencer;
  import mes_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [DUR_W-1:0] DUR_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [LEN_W-1:0]   len;
    logic [PBITS_W-1:0] bits;
  } text_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DUR_W-1:0]  dur;
    logic              last;
  } key_event_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [OP_W-1:0]      op = OP_CHAR;
  logic [LEN_W-1:0]     pattern_length = '0;
  logic [PBITS_W-1:0]   pattern_bits = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [KIND_W-1:0]    event_kind;
  logic [DUR_W-1:0]     duration;
  logic                 last;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_DIT;
  logic [DUR_W-1:0]     cfg_data = '0;

  morse_element_sequencer uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .pattern_length(pattern_length),
    .pattern_bits(pattern_bits),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .event_kind(event_kind),
    .duration(duration),
    .last(last),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  text_item_t text_backlog[$];
  key_event_t keying_events[$];
  key_event_t sounded[$];

  mes_cfg_t    timing;
  mes_held_t   held_text[PROSIGN_DEPTH];
  int unsigned escapes_seen = 0;
  int unsigned held_n = 0;

  int          offered_n = 0;
  int          accepted_n = 0;
  int          escape_items = 0;
  int          unused_items = 0;
  int          events_checked = 0;
  int          mismatches = 0;
  int          input_stalls = 0;
  int          settings_n = 0;
  int          send_gap = 0;
  int          sink_gap = 0;
  bit          send_steady = 1'b0;
  bit          sink_steady = 1'b0;
  bit          pressure_go = 1'b0;
  logic        sink_hold = 1'b0;
  text_item_t  next_text;
  key_event_t  want;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int idle_len(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic key_event_t mk_event(logic [KIND_W-1:0] kind, logic [DUR_W-1:0] dur);
    key_event_t e;
    e.kind = kind;
    e.dur = dur;
    e.last = 1'b0;
    return e;
  endfunction

  task automatic sound_text(input mes_held_t it, input bit joined);
    int i;
    if (it.is_space) begin
      sounded.push_back(mk_event(KIND_PAUSE, (timing.word_gap > timing.letter_gap) ?
                                 timing.word_gap - timing.letter_gap : '0));
    end else begin
      for (i = 0; i < int'(it.len); i++) begin
        sounded.push_back(mk_event(KIND_DOWN, it.bits[i] ? timing.dah : timing.dit));
        sounded.push_back(mk_event(KIND_UP, (i + 1 < int'(it.len) || joined) ?
                                   timing.element_gap : timing.letter_gap));
      end
    end
  endtask

  task automatic key_text_item(input logic [OP_W-1:0] op_i, input logic [LEN_W-1:0] len_i,
                               input logic [PBITS_W-1:0] bits_i);
    mes_held_t it;
    int i;
    sounded.delete();
    if (op_i == OP_ESCAPE) begin
      escape_items++;
      if (escapes_seen + 1 < PROSIGN_DEPTH) escapes_seen++;
    end else if (op_i == OP_UNUSED) begin
      unused_items++;
    end else begin
      it.is_space = (op_i == OP_SPACE);
      it.len = it.is_space ? '0 : ((len_i > MAX_ELEMENTS) ? LEN_W'(MAX_ELEMENTS) : len_i);
      it.bits = it.is_space ? '0 : bits_i;
      if (escapes_seen == 0) begin
        sound_text(it, 1'b0);
      end else begin
        held_text[held_n] = it;
        held_n++;
        if (held_n >= escapes_seen + 1) begin
          for (i = 0; i < int'(held_n); i++) sound_text(held_text[i], i + 1 != int'(held_n));
          held_n = 0;
          escapes_seen = 0;
        end
      end
    end
    if (sounded.size() > 0) begin
      sounded[sounded.size() - 1].last = 1'b1;
      foreach (sounded[k]) keying_events.push_back(sounded[k]);
    end
  endtask

  function automatic void note_mismatch(string field, int unsigned exp_v, int unsigned got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("Mismatch in %s of event %0d: expected %0d, got %0d",
               field, events_checked, exp_v, got_v);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        key_text_item(op, pattern_length, pattern_bits);
        accepted_n++;
      end else if (in_valid) begin
        input_stalls++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (text_backlog.size() > 0) begin
          next_text = text_backlog.pop_front();
          op <= next_text.op;
          pattern_length <= next_text.len;
          pattern_bits <= next_text.bits;
          in_valid <= 1'b1;
          send_gap = idle_len(send_steady);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (keying_events.size() == 0) begin
          note_mismatch("presence (no event due)", 0, 1);
        end else begin
          want = keying_events.pop_front();
          if (event_kind !== want.kind) note_mismatch("event_kind", want.kind, event_kind);
          if (duration !== want.dur) note_mismatch("duration", want.dur, duration);
          if (last !== want.last) note_mismatch("last", want.last, last);
        end
        events_checked++;
      end
      if (sink_gap > 0) begin
        sink_gap--;
        out_ready <= 1'b0;
      end else if (sink_hold) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        sink_gap = idle_len(sink_steady);
      end
    end
  end

  initial begin
    wait (pressure_go);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (400) @(posedge clk);
    sink_hold <= 1'b0;
  end

  task automatic offer(input logic [OP_W-1:0] o, input logic [LEN_W-1:0] l,
                       input logic [PBITS_W-1:0] b);
    text_item_t t;
    t.op = o;
    t.len = l;
    t.bits = b;
    text_backlog.push_back(t);
    offered_n++;
  endtask

  task automatic offer_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) offer(OP_CHAR, '0, PBITS_W'($urandom_range(0, 255)));
    else if (r < 16) offer(OP_CHAR, LEN_W'($urandom_range(9, 15)), PBITS_W'($urandom_range(0, 255)));
    else offer(OP_CHAR, LEN_W'($urandom_range(1, 8)), PBITS_W'($urandom_range(0, 255)));
  endtask

  task automatic offer_space();
    offer(OP_SPACE, LEN_W'($urandom_range(0, 15)), PBITS_W'($urandom_range(0, 255)));
  endtask

  task automatic offer_escape();
    offer(OP_ESCAPE, LEN_W'($urandom_range(0, 15)), PBITS_W'($urandom_range(0, 255)));
  endtask

  task automatic offer_random(input int count);
    int start;
    int r;
    int k;
    int n;
    start = offered_n;
    while (offered_n - start < count) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        offer_char();
      end else if (r < 65) begin
        offer_space();
      end else if (r < 69) begin
        offer(OP_UNUSED, LEN_W'($urandom_range(0, 15)), PBITS_W'($urandom_range(0, 255)));
      end else if (r < 72) begin
        offer_escape();
      end else begin
        k = $urandom_range(1, 5);
        n = ((k < PROSIGN_DEPTH - 1) ? k : PROSIGN_DEPTH - 1) + 1;
        if ($urandom_range(0, 9) == 0) n--;
        repeat (k) offer_escape();
        repeat (n) begin
          if ($urandom_range(0, 4) == 0) offer_space();
          else offer_char();
        end
      end
    end
    repeat (PROSIGN_DEPTH) offer_char();
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_DIT: timing.dit = val;
      CFG_DAH: timing.dah = val;
      CFG_ELEMENT_GAP: timing.element_gap = val;
      CFG_LETTER_GAP: timing.letter_gap = val;
      CFG_WORD_GAP: timing.word_gap = val;
      default: ;
    endcase
  endtask

  task automatic set_timing(input logic [DUR_W-1:0] dit, input logic [DUR_W-1:0] dah,
                            input logic [DUR_W-1:0] egap, input logic [DUR_W-1:0] lgap,
                            input logic [DUR_W-1:0] wgap);
    write_reg(CFG_DIT, dit);
    write_reg(CFG_DAH, dah);
    write_reg(CFG_ELEMENT_GAP, egap);
    write_reg(CFG_LETTER_GAP, lgap);
    write_reg(CFG_WORD_GAP, wgap);
    settings_n++;
    @(negedge clk);
  endtask

  function automatic logic [DUR_W-1:0] rand_dur();
    return DUR_W'($urandom_range(1, 32'hFFFFFF));
  endfunction

  task automatic drain();
    do @(negedge clk); while (accepted_n != offered_n || keying_events.size() != 0);
    repeat (32) @(negedge clk);
  endtask

  initial begin
    timing.dit = DIT_RESET;
    timing.dah = DAH_RESET;
    timing.element_gap = ELEMENT_GAP_RESET;
    timing.letter_gap = LETTER_GAP_RESET;
    timing.word_gap = WORD_GAP_RESET;
    settings_n = 1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Single characters at the field extremes, an unknown one, a space and the unused code.
    offer(OP_CHAR, 4'd1, 8'h00);
    offer(OP_CHAR, 4'd8, 8'hFF);
    offer(OP_CHAR, 4'd8, 8'h00);
    offer(OP_CHAR, 4'd15, 8'hA5);
    offer(OP_CHAR, 4'd0, 8'hFF);
    offer(OP_SPACE, 4'd15, 8'hFF);
    offer(OP_UNUSED, 4'd15, 8'hFF);
    // A two-letter prosign.
    offer(OP_ESCAPE, 4'd0, 8'h00);
    offer(OP_CHAR, 4'd2, 8'h02);
    offer(OP_CHAR, 4'd3, 8'h02);
    // A prosign that ends in a word space.
    offer(OP_ESCAPE, 4'd0, 8'h00);
    offer(OP_ESCAPE, 4'd15, 8'hFF);
    offer(OP_CHAR, 4'd3, 8'h05);
    offer(OP_CHAR, 4'd2, 8'h01);
    offer(OP_SPACE, 4'd0, 8'h00);
    // A prosign that ends in an unknown character.
    offer(OP_ESCAPE, 4'd0, 8'h00);
    offer(OP_CHAR, 4'd4, 8'h09);
    offer(OP_CHAR, 4'd0, 8'h3C);
    // More escapes than the prosign can hold; the extra one is dropped.
    repeat (4) offer(OP_ESCAPE, 4'd0, 8'h00);
    offer(OP_SPACE, 4'd1, 8'h01);
    offer(OP_CHAR, 4'd1, 8'h01);
    offer(OP_CHAR, 4'd5, 8'h1F);
    offer(OP_CHAR, 4'd12, 8'hC3);
    drain();

    set_timing(rand_dur(), rand_dur(), rand_dur(), rand_dur(), rand_dur());
    offer_random(100);
    drain();

    set_timing(24'd1, 24'd1, 24'd1, 24'd1, 24'd1);
    send_steady = 1'b1;
    offer_random(80);
    drain();

    set_timing(DUR_MAX, 24'd1, DUR_MAX, DUR_MAX, 24'd1);
    sink_steady = 1'b1;
    offer_random(80);
    drain();

    set_timing(24'd3, 24'd9, 24'd3, 24'd9, 24'd21);
    sink_steady = 1'b0;
    pressure_go = 1'b1;
    offer_random(80);
    drain();

    set_timing(DIT_RESET, DAH_RESET, ELEMENT_GAP_RESET, LETTER_GAP_RESET, WORD_GAP_RESET);
    send_steady = 1'b0;
    offer_random(120);
    drain();

    $display("Sent %0d text items (%0d escapes, %0d with the unused code) and checked %0d key events",
             accepted_n, escape_items, unused_items, events_checked);
    $display("over %0d timing settings; the input was held off for %0d cycles, %0d mismatches.",
             settings_n, input_stalls, mismatches);
    if (mismatches == 0 && keying_events.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
